### src/pmu_pkg.sv
// ----------------------------------------------------------------------------
// pmu_pkg: shared types and constants of the performance monitor
// Counter count, register addresses, event numbers and the front-to-back item.
// ----------------------------------------------------------------------------
`default_nettype none

package pmu_pkg;

  localparam int NUM_COUNTERS = 6;
  localparam int CIDX_W = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;

  localparam logic [4:0] CYC_ID = 5'h1F;
  localparam logic [7:0] EV_SWINC = 8'h00;
  localparam logic [7:0] EV_INSN = 8'h08;
  localparam logic [7:0] EV_CYCLES = 8'h11;
  localparam logic [31:0] CEID0_VALUE = 32'h0002_0101;
  localparam logic [7:0] IMPL_RESET = 8'd65;

  localparam logic [31:0] IMPL_MASK =
      32'h8000_0000 | ((32'd1 << NUM_COUNTERS) - 32'd1);

  typedef enum logic [1:0] {
    FN_WRITE = 2'd0,
    FN_READ  = 2'd1,
    FN_TICK  = 2'd2,
    FN_NOP   = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    RA_CTRL   = 4'd0,
    RA_ENSET  = 4'd1,
    RA_ENCLR  = 4'd2,
    RA_OVSR   = 4'd3,
    RA_SWINC  = 4'd4,
    RA_SEL    = 4'd5,
    RA_CCNT   = 4'd6,
    RA_EVTYPE = 4'd7,
    RA_EVCNT  = 4'd8,
    RA_USEREN = 4'd9,
    RA_INTSET = 4'd10,
    RA_INTCLR = 4'd11,
    RA_CEID0  = 4'd12
  } reg_addr_t;

  // item handed from the front to the back through the queue
  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  reg_addr;
    logic [31:0] wdata;
    logic [15:0] instr_count;
    logic [15:0] cycle_count;
    logic        user_mode;
    logic        sel_ok;
  } pmu_op_t;

  localparam int QDEPTH = 2;

endpackage

`default_nettype wire

### src/pmu_if.sv
// ----------------------------------------------------------------------------
// pmu_in_if / pmu_out_if: valid-ready channels of the performance monitor
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pmu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [3:0]  reg_addr;
  logic [31:0] wdata;
  logic [15:0] instr_count;
  logic [15:0] cycle_count;
  logic        user_mode;

  modport source (output valid, func, reg_addr, wdata, instr_count, cycle_count,
                  user_mode, input ready);
  modport sink (input valid, func, reg_addr, wdata, instr_count, cycle_count,
                user_mode, output ready);
endinterface

interface pmu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] rdata;
  logic [31:0] overflow_mask;
  logic        irq;
  logic        bad_access;

  modport source (output valid, rdata, overflow_mask, irq, bad_access, input ready);
  modport sink (input valid, rdata, overflow_mask, irq, bad_access, output ready);
endinterface

`default_nettype wire

### src/perf_monitor_unit.sv
// Path: an input transfer goes through the queue stage, then the result register.
// Throughput: one item per cycle unless the output stalls; all counters update in parallel
//   with fixed adders in the back end, and a two-entry queue separates front and back stalls.
// Reset: synchronous active-low rst_n clears all counters and control state and
//   loads the implementer code with 65; the block is ready the cycle after reset.
// ----------------------------------------------------------------------------
// perf_monitor_unit: performance monitor top level
// Connects the input queue front end to the counter bank back end.
// ----------------------------------------------------------------------------
`default_nettype none

module perf_monitor_unit import pmu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  pmu_in_if.sink          in_ch,
  pmu_out_if.source       out_ch
);

  pmu_op_t op;
  logic    op_valid, op_ready;

  // front end: accept and queue
  pmu_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .op(op), .op_valid(op_valid), .op_ready(op_ready)
  );

  // back end: execute and return result
  pmu_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .op(op), .op_valid(op_valid), .op_ready(op_ready), .out_ch(out_ch)
  );

endmodule

`default_nettype wire

### src/pmu_front.sv
// ----------------------------------------------------------------------------
// pmu_front: input stage and decode queue
// Accepts items, checks selection writes, and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pmu_front import pmu_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  pmu_in_if.sink       in_ch,
  output pmu_op_t      op,
  output logic         op_valid,
  input  wire logic    op_ready
);

  pmu_op_t               q_r [QDEPTH];
  logic [0:0]            wp_r, rp_r;
  logic [1:0]            cnt_r;
  logic                  push, pop;
  pmu_op_t               dec;

  // classify selection writes early
  always_comb begin
    dec.func        = in_ch.func;
    dec.reg_addr    = in_ch.reg_addr;
    dec.wdata       = in_ch.wdata;
    dec.instr_count = in_ch.instr_count;
    dec.cycle_count = in_ch.cycle_count;
    dec.user_mode   = in_ch.user_mode;
    dec.sel_ok      = (in_ch.wdata < 32'(NUM_COUNTERS)) ||
                      (in_ch.wdata == {27'd0, CYC_ID});
  end

  assign in_ch.ready = (cnt_r != 2'(QDEPTH));
  assign push = in_ch.valid && in_ch.ready;
  assign op_valid = (cnt_r != 2'd0);
  assign pop = op_valid && op_ready;
  assign op = q_r[rp_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= dec;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef ASSERT_OFF
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(QDEPTH)) else $error("queue overfilled");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 2'd1) else $error("count slip");
  a_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> !op_valid) else $error("valid while empty");
`endif

endmodule

`default_nettype wire

### src/pmu_back.sv
// ----------------------------------------------------------------------------
// pmu_back: counter bank and register file
// Executes one queued item per cycle unless the output stalls, and registers its result.
// ----------------------------------------------------------------------------
`default_nettype none

module pmu_back import pmu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  input  wire pmu_op_t     op,
  input  wire logic        op_valid,
  output logic             op_ready,
  pmu_out_if.source        out_ch
);

  logic [31:0] cnt_r [NUM_COUNTERS];
  logic [31:0] cnt_nxt [NUM_COUNTERS];
  logic [9:0]  evt_r [NUM_COUNTERS];
  logic [9:0]  evt_nxt [NUM_COUNTERS];
  logic [31:0] ccnt_r, ccnt_nxt;
  logic [31:0] en_r, en_nxt, inten_r, inten_nxt, ovs_r, ovs_nxt;
  logic [3:0]  ctrl_r, ctrl_nxt;
  logic [4:0]  sel_r, sel_nxt;
  logic [31:0] evrb_r, evrb_nxt;
  logic        usr_r, usr_nxt;
  logic [5:0]  rem_r, rem_nxt;
  logic [7:0]  impl_r;

  logic        ov_valid_r;
  logic [31:0] rd_r, rd_nxt, ovm_r, ovm_nxt;
  logic        bad_r, bad_nxt;

  logic        go;
  logic [16:0] total;
  logic [16:0] cyc;
  logic        sel_evt;
  logic [CIDX_W-1:0] sidx, widx;
  logic [32:0] sum;

  assign op_ready = !ov_valid_r || out_ch.ready;
  assign go = op_valid && op_ready;
  assign sel_evt = (sel_r < 5'(NUM_COUNTERS));
  assign sidx = sel_r[CIDX_W-1:0];
  assign widx = op.wdata[CIDX_W-1:0];
  assign total = {1'b0, op.cycle_count} + {11'd0, rem_r};
  assign cyc = ctrl_r[1] ? {6'd0, total[16:6]} : total;

  // execute the item
  always_comb begin
    for (int i = 0; i < NUM_COUNTERS; i++) begin
      cnt_nxt[i] = cnt_r[i];
      evt_nxt[i] = evt_r[i];
    end
    ccnt_nxt = ccnt_r; en_nxt = en_r; inten_nxt = inten_r; ovs_nxt = ovs_r;
    ctrl_nxt = ctrl_r; sel_nxt = sel_r; evrb_nxt = evrb_r; usr_nxt = usr_r;
    rem_nxt = rem_r; rd_nxt = '0; ovm_nxt = '0; bad_nxt = 1'b0; sum = '0;
    case (func_t'(op.func))
      FN_WRITE: begin
        case (reg_addr_t'(op.reg_addr))
          RA_CTRL: begin
            if (op.wdata[2]) ccnt_nxt = '0;
            if (op.wdata[1]) for (int i = 0; i < NUM_COUNTERS; i++) cnt_nxt[i] = '0;
            ctrl_nxt = {op.wdata[5], op.wdata[4], op.wdata[3], op.wdata[0]};
          end
          RA_ENSET:  en_nxt = en_r | (op.wdata & IMPL_MASK);
          RA_ENCLR:  en_nxt = en_r & ~op.wdata;
          RA_OVSR:   ovs_nxt = ovs_r & ~op.wdata;
          RA_SWINC: begin
            for (int i = 0; i < NUM_COUNTERS; i++) begin
              if (op.wdata[i] && evt_r[i][7:0] == EV_SWINC && ctrl_r[0] && en_r[i] &&
                  !(op.user_mode && evt_r[i][8]) && !(!op.user_mode && evt_r[i][9])) begin
                cnt_nxt[i] = cnt_r[i] + 32'd1;
                if (cnt_r[i] == 32'hFFFF_FFFF) begin
                  ovm_nxt[i] = 1'b1;
                  if (inten_r[i]) ovs_nxt[i] = 1'b1;
                end
              end
            end
          end
          RA_SEL: begin
            if (!op.sel_ok) bad_nxt = 1'b1;
            else begin
              sel_nxt = op.wdata[4:0];
              if (op.wdata[4:0] == CYC_ID) evrb_nxt = {24'd0, EV_CYCLES};
              else evrb_nxt = {24'd0, evt_r[widx][7:0]};
            end
          end
          RA_CCNT: ccnt_nxt = op.wdata;
          RA_EVTYPE: begin
            evrb_nxt = op.wdata & 32'hC000_00FF;
            if (!sel_evt) bad_nxt = 1'b1;
            else evt_nxt[sidx] = {op.wdata[31], op.wdata[30], op.wdata[7:0]};
          end
          RA_EVCNT: begin
            if (sel_evt) cnt_nxt[sidx] = op.wdata;
            else ccnt_nxt = op.wdata;
          end
          RA_USEREN: usr_nxt = op.wdata[0];
          RA_INTSET: inten_nxt = inten_r | (op.wdata & IMPL_MASK);
          RA_INTCLR: inten_nxt = inten_r & ~op.wdata;
          default: ;
        endcase
      end
      FN_READ: begin
        case (reg_addr_t'(op.reg_addr))
          RA_CTRL: rd_nxt = {impl_r, 24'd0} | (32'(NUM_COUNTERS) << 11) |
                            {26'd0, ctrl_r[3:1], 2'd0, ctrl_r[0]};
          RA_ENSET, RA_ENCLR:   rd_nxt = en_r;
          RA_OVSR:              rd_nxt = ovs_r;
          RA_SEL:               rd_nxt = {27'd0, sel_r};
          RA_CCNT:              rd_nxt = ccnt_r;
          RA_EVTYPE:            rd_nxt = evrb_r;
          RA_EVCNT:             rd_nxt = sel_evt ? cnt_r[sidx] : ccnt_r;
          RA_USEREN:            rd_nxt = {31'd0, usr_r};
          RA_INTSET, RA_INTCLR: rd_nxt = inten_r;
          RA_CEID0:             rd_nxt = CEID0_VALUE;
          default: ;
        endcase
      end
      FN_TICK: begin
        if (ctrl_r[0]) begin
          // parallel event counter adders
          for (int i = 0; i < NUM_COUNTERS; i++) begin
            if (en_r[i] && !(op.user_mode && evt_r[i][8]) &&
                !(!op.user_mode && evt_r[i][9]) &&
                (evt_r[i][7:0] == EV_INSN || evt_r[i][7:0] == EV_CYCLES)) begin
              sum = {1'b0, cnt_r[i]} + ((evt_r[i][7:0] == EV_INSN) ?
                    {17'd0, op.instr_count} : {16'd0, cyc});
              cnt_nxt[i] = sum[31:0];
              if (sum[32]) begin
                ovm_nxt[i] = 1'b1;
                if (inten_r[i]) ovs_nxt[i] = 1'b1;
              end
            end
          end
          // cycle counter, no privilege filter
          if (en_r[CYC_ID]) begin
            sum = {1'b0, ccnt_r} + {16'd0, cyc};
            ccnt_nxt = sum[31:0];
            if (sum[32]) begin
              ovm_nxt[CYC_ID] = 1'b1;
              if (inten_r[CYC_ID]) ovs_nxt[CYC_ID] = 1'b1;
            end
          end
          rem_nxt = ctrl_r[1] ? total[5:0] : 6'd0;
        end
      end
      default: ;
    endcase
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        cnt_r[i] <= '0;
        evt_r[i] <= '0;
      end
      ccnt_r <= '0; en_r <= '0; inten_r <= '0; ovs_r <= '0; ctrl_r <= '0;
      sel_r <= '0; evrb_r <= '0; usr_r <= 1'b0; rem_r <= '0;
    end else if (go) begin
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        cnt_r[i] <= cnt_nxt[i];
        evt_r[i] <= evt_nxt[i];
      end
      ccnt_r <= ccnt_nxt; en_r <= en_nxt; inten_r <= inten_nxt; ovs_r <= ovs_nxt;
      ctrl_r <= ctrl_nxt; sel_r <= sel_nxt; evrb_r <= evrb_nxt; usr_r <= usr_nxt;
      rem_r <= rem_nxt;
    end
  end

  // implementer register
  always_ff @(posedge clk) begin
    if (!rst_n) impl_r <= IMPL_RESET;
    else if (cfg_we) impl_r <= cfg_wdata;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) ov_valid_r <= 1'b0;
    else if (op_ready) ov_valid_r <= op_valid;
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rd_r <= rd_nxt;
      ovm_r <= ovm_nxt;
      bad_r <= bad_nxt;
    end
  end

  assign out_ch.valid = ov_valid_r;
  assign out_ch.rdata = rd_r;
  assign out_ch.overflow_mask = ovm_r;
  assign out_ch.irq = (ovs_r != 32'd0);
  assign out_ch.bad_access = bad_r;

`ifndef ASSERT_OFF
  a_ovs_impl: assert property (@(posedge clk) disable iff (!rst_n)
    (ovs_r & ~IMPL_MASK) == 32'd0) else $error("overflow on missing counter");
  a_en_impl: assert property (@(posedge clk) disable iff (!rst_n)
    (en_r & ~IMPL_MASK) == 32'd0) else $error("enable on missing counter");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> $stable(rd_r) && $stable(ovm_r))
    else $error("result changed while stalled");
  a_sel_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (sel_r < 5'(NUM_COUNTERS)) || (sel_r == CYC_ID)) else $error("bad selection");
`endif

endmodule

`default_nettype wire
